>>> hdl/cblt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cblt_pkg
// Shared sizes, command and result codes, and record layout for the card
// block-list table.
// ----------------------------------------------------------------------------
package cblt_pkg;

  localparam int unsigned ENTRIES = 1024;       // records per table
  localparam int unsigned IDX_W   = $clog2(ENTRIES);
  localparam int unsigned CNT_W   = $clog2(ENTRIES + 1);
  localparam int unsigned ADDR_W  = IDX_W + 1;  // table select + record index

  localparam int unsigned KEY_W   = 24;
  localparam int unsigned DAT_W   = 8;
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned CODE_W  = 2;
  localparam int unsigned REC_W   = KEY_W + 1 + DAT_W;

  localparam logic [KEY_W-1:0] KEY_RESERVED = '1;
  localparam logic [DAT_W-1:0] NO_DATA      = '1;

  // commands
  localparam logic [CMD_W-1:0] CMD_CHECK   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BLOCK   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RECORD  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_UNBLOCK = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd4;

  // result codes
  localparam logic [CODE_W-1:0] RES_FAIL    = 2'd0;
  localparam logic [CODE_W-1:0] RES_OK      = 2'd1;
  localparam logic [CODE_W-1:0] RES_UPDATED = 2'd2;
  localparam logic [CODE_W-1:0] RES_ABSENT  = 2'd0;
  localparam logic [CODE_W-1:0] RES_BLOCKED = 2'd1;
  localparam logic [CODE_W-1:0] RES_LISTED  = 2'd2;

  // stored record, data byte in the low bits
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             blocked;
    logic [DAT_W-1:0] data;
  } rec_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             sel;
    logic [KEY_W-1:0] key;
    logic [DAT_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    rec_t              wdata;
  } mem_req_t;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
    logic [DAT_W-1:0]  data;
  } res_t;

endpackage

>>> hdl/card_block_list_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// card_block_list_table
// Two append-only card tables (normal, manager) with linear key search and
// in-place update of the found record.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                         tuser
//  s_axis   in   [23:0] card_key [31:24] value [2:0] cmd [3] list_select
//  m_axis   out  [7:0] data                    [1:0] code
//
//  One word in flight: a scan of n records (n = fill count of the selected
//  table, at most ENTRIES, fewer on an early hit) runs n reads, a read-latency
//  step, then the apply and result steps; the result then goes to m_axis
//  through the output register. The next word is taken once the controller is idle.
//  Clear, reserved key, unused commands and empty tables skip the scan and
//  go from accept straight to the apply and result steps.
//  Reset zeroes both fill counts; record RAM is not cleared.
//  A finished result sits in the output register; the next word is taken
//  while it waits, and the controller holds its own result until free.
// ----------------------------------------------------------------------------
module card_block_list_table import cblt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [23:0] card_key, [31:24] value
  input  logic [3:0]  s_axis_tuser_i,   // [2:0] cmd, [3] list_select
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] data
  output logic [1:0]  m_axis_tuser_o    // [1:0] code
);

  item_t    in_item;
  mem_req_t mem_req;
  rec_t     mem_rdata;
  res_t     res;
  logic     res_ready;

  logic              out_valid_q;
  logic [CODE_W-1:0] out_code_q;
  logic [DAT_W-1:0]  out_data_q;

  assign in_item = '{cmd:   s_axis_tuser_i[CMD_W-1:0],
                     sel:   s_axis_tuser_i[CMD_W],
                     key:   s_axis_tdata_i[KEY_W-1:0],
                     value: s_axis_tdata_i[KEY_W +: DAT_W]};

  cblt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_item_i   (in_item),
    .mem_o       (mem_req),
    .mem_rdata_i (mem_rdata),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  cblt_ram #(
    .DATA_W (REC_W),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // output register: free when empty or being drained this cycle
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res.valid) begin
      out_code_q <= res.code;
      out_data_q <= res.data;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_code_q;

endmodule

>>> hdl/cblt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cblt_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module cblt_ram #(
  parameter int unsigned DATA_W = 33,
  parameter int unsigned ADDR_W = 11
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [(2**ADDR_W)];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> hdl/cblt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cblt_ctrl
// Search sequencer: linear scan of the selected table, then one
// read-modify-write step, fill counts and result.
// ----------------------------------------------------------------------------
module cblt_ctrl import cblt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  item_t       in_item_i,
  output mem_req_t    mem_o,
  input  rec_t        mem_rdata_i,
  output res_t        res_o,
  input  logic        res_ready_i
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_APPLY  = 4'b0100,
    ST_RESP   = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  item_t             item_q;
  logic [CNT_W-1:0]  fill_q [2];
  logic [CNT_W-1:0]  n_q;
  logic [CNT_W-1:0]  issue_q, issue_d;
  logic              pend_q, pend_d;
  logic [IDX_W-1:0]  pend_idx_q;
  logic              hit_q;
  logic [IDX_W-1:0]  hit_idx_q;
  rec_t              hit_rec_q;
  logic [CODE_W-1:0] code_q, code_d;
  logic [DAT_W-1:0]  data_q, data_d;

  logic accept, issue, match, last, need_search, reserved, room;
  logic do_append, do_clear;
  logic [CNT_W-1:0] n_in;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign n_in       = fill_q[in_item_i.sel];
  assign need_search = (in_item_i.cmd <= CMD_UNBLOCK) && (in_item_i.key != KEY_RESERVED)
                       && (n_in != '0);

  // scan: issue one read per cycle, compare each returned word in the cycle after its read
  assign issue = (state_q == ST_SEARCH) && (issue_q < n_q);
  assign match = pend_q && (mem_rdata_i.key == item_q.key);
  assign last  = pend_q && ((CNT_W'(pend_idx_q) + CNT_W'(1)) == n_q);

  assign reserved = (item_q.key == KEY_RESERVED);
  assign room     = fill_q[item_q.sel] < CNT_W'(ENTRIES);

  always_comb begin
    state_d = state_q;
    issue_d = issue_q;
    pend_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        issue_d = '0;
        if (accept) begin
          state_d = need_search ? ST_SEARCH : ST_APPLY;
        end
      end
      ST_SEARCH: begin
        if (match || last) begin
          state_d = ST_APPLY;
        end else begin
          pend_d = issue;
          if (issue) begin
            issue_d = issue_q + CNT_W'(1);
          end
        end
      end
      ST_APPLY: state_d = ST_RESP;
      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // read-modify-write decision
  always_comb begin
    mem_o       = '0;
    mem_o.re    = pend_d;
    mem_o.raddr = {item_q.sel, issue_q[IDX_W-1:0]};
    code_d      = RES_FAIL;
    data_d      = NO_DATA;
    do_append   = 1'b0;
    do_clear    = 1'b0;
    mem_o.wdata = hit_rec_q;
    mem_o.waddr = {item_q.sel, hit_idx_q};
    case (item_q.cmd)
      CMD_CHECK: begin
        if (hit_q) begin
          data_d = hit_rec_q.data;
          code_d = hit_rec_q.blocked ? RES_BLOCKED : RES_LISTED;
        end else begin
          code_d = RES_ABSENT;
        end
      end
      CMD_BLOCK: begin
        if (reserved) begin
          code_d = room ? RES_OK : RES_FAIL;
        end else if (hit_q) begin
          mem_o.we            = 1'b1;
          mem_o.wdata.blocked = 1'b1;
          code_d              = RES_UPDATED;
        end else if (room) begin
          do_append   = 1'b1;
          mem_o.wdata = '{key: item_q.key, blocked: 1'b1, data: NO_DATA};
          code_d      = RES_OK;
        end
      end
      CMD_RECORD: begin
        if (reserved) begin
          code_d = room ? RES_OK : RES_FAIL;
        end else if (hit_q) begin
          mem_o.we            = 1'b1;
          mem_o.wdata.blocked = 1'b0;
          mem_o.wdata.data    = item_q.value;
          code_d              = RES_OK;
        end else if (room) begin
          do_append   = 1'b1;
          mem_o.wdata = '{key: item_q.key, blocked: 1'b0, data: item_q.value};
          code_d      = RES_OK;
        end
      end
      CMD_UNBLOCK: begin
        if (hit_q) begin
          mem_o.we            = 1'b1;
          mem_o.wdata.blocked = 1'b0;
          code_d              = RES_OK;
        end else begin
          code_d = room ? RES_OK : RES_FAIL;
        end
      end
      CMD_CLEAR: begin
        do_clear = 1'b1;
        code_d   = RES_OK;
      end
      default: code_d = RES_FAIL;
    endcase
    if (do_append) begin
      mem_o.we    = 1'b1;
      mem_o.waddr = {item_q.sel, fill_q[item_q.sel][IDX_W-1:0]};
    end
    if (state_q != ST_APPLY) begin
      mem_o.we = 1'b0;
      do_append = 1'b0;
      do_clear  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q[0] <= '0;
      fill_q[1] <= '0;
      issue_q   <= '0;
      pend_q    <= 1'b0;
      hit_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
      pend_q  <= pend_d;
      if (accept) begin
        hit_q <= 1'b0;
      end else if (state_q == ST_SEARCH && match) begin
        hit_q <= 1'b1;
      end
      if (do_clear) begin
        fill_q[0] <= '0;
        fill_q[1] <= '0;
      end else if (do_append) begin
        fill_q[item_q.sel] <= fill_q[item_q.sel] + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
      n_q    <= n_in;
    end
    pend_idx_q <= issue_q[IDX_W-1:0];
    if (state_q == ST_SEARCH && match) begin
      hit_idx_q <= pend_idx_q;
      hit_rec_q <= mem_rdata_i;
    end
    if (state_q == ST_APPLY) begin
      code_q <= code_d;
      data_q <= data_d;
    end
  end

  assign res_o = '{valid: (state_q == ST_RESP), code: code_q, data: data_q};

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q[0] <= CNT_W'(ENTRIES)) && (fill_q[1] <= CNT_W'(ENTRIES)))
    else $error("fill count above table size");

  a_write_apply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_o.we |-> (state_q == ST_APPLY))
    else $error("memory write outside apply step");

  a_hit_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPLY && hit_q) |-> (hit_rec_q.key == item_q.key))
    else $error("hit record key differs from item key");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_o.re |-> (state_q == ST_SEARCH && issue_q < n_q))
    else $error("read beyond fill count");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("accepted word left controller idle");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the card block-list table. A directed table covers
// empty tables, the reserved key, every command and the unused command codes.
// The manager table is then filled to capacity and probed while full. A
// random phase follows, with a small key pool so hits are common. Each
// accepted word runs through a local model of both tables, and each result
// word is compared in order. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  import cblt_pkg::*;

  localparam int unsigned N_RANDOM = 580;
  localparam logic [CMD_W-1:0] CMD_SPARE5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [DAT_W-1:0]  data;
  } verdict_t;

  typedef struct {
    item_t    w;
    bit       typed;
    verdict_t v;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [31:0] s_tdata = '0;
  logic [3:0]  s_tuser = '0;
  logic        m_ready = 1'b0;
  logic        s_ready;
  logic        m_valid;
  logic [7:0]  m_tdata;
  logic [1:0]  m_tuser;

  // local copy of both tables
  rec_t        card_store [2*ENTRIES];
  int unsigned fill_cnt [2];

  verdict_t    verdict_q [$];
  row_t        dir_rows [$];
  logic [KEY_W-1:0] key_pool [16];

  int unsigned err_cnt = 0;
  int unsigned cmd_tally [8];
  int unsigned hit_cnt = 0;
  int unsigned reject_cnt = 0;
  int unsigned peak_fill = 0;
  bit          calm = 1'b0;

  card_block_list_table u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one; none during calm stretches.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Applies one word to the table copy and returns the result it gives.
  function automatic verdict_t card_table_apply(input item_t w);
    verdict_t    v;
    int unsigned base, n, idx, i;
    bit          hit, room, rsv;
    base = w.sel ? ENTRIES : 0;
    n    = fill_cnt[w.sel];
    room = n < ENTRIES;
    rsv  = (w.key == KEY_RESERVED);
    hit  = 1'b0;
    idx  = 0;
    v.code = RES_FAIL;
    v.data = NO_DATA;
    if (!rsv && w.cmd <= CMD_UNBLOCK) begin
      for (i = 0; i < n && !hit; i++) begin
        if (card_store[base + i].key == w.key) begin
          hit = 1'b1;
          idx = base + i;
        end
      end
    end
    case (w.cmd)
      CMD_CHECK: begin
        if (hit) begin
          v.data = card_store[idx].data;
          v.code = card_store[idx].blocked ? RES_BLOCKED : RES_LISTED;
        end
      end
      CMD_BLOCK: begin
        if (rsv) begin
          v.code = room ? RES_OK : RES_FAIL;
        end else if (hit) begin
          card_store[idx].blocked = 1'b1;
          v.code = RES_UPDATED;
        end else if (room) begin
          card_store[base + n] = '{w.key, 1'b1, NO_DATA};
          fill_cnt[w.sel]++;
          v.code = RES_OK;
        end
      end
      CMD_RECORD: begin
        if (rsv) begin
          v.code = room ? RES_OK : RES_FAIL;
        end else if (hit) begin
          card_store[idx].blocked = 1'b0;
          card_store[idx].data    = w.value;
          v.code = RES_OK;
        end else if (room) begin
          card_store[base + n] = '{w.key, 1'b0, w.value};
          fill_cnt[w.sel]++;
          v.code = RES_OK;
        end
      end
      CMD_UNBLOCK: begin
        if (hit) begin
          card_store[idx].blocked = 1'b0;
          v.code = RES_OK;
        end else begin
          v.code = room ? RES_OK : RES_FAIL;
        end
      end
      CMD_CLEAR: begin
        fill_cnt[0] = 0;
        fill_cnt[1] = 0;
        v.code = RES_OK;
      end
      default: v.code = RES_FAIL;
    endcase
    if (hit) hit_cnt++;
    if (w.cmd inside {CMD_BLOCK, CMD_RECORD, CMD_UNBLOCK} && v.code == RES_FAIL)
      reject_cnt++;
    if (fill_cnt[w.sel] > peak_fill) peak_fill = fill_cnt[w.sel];
    return v;
  endfunction

  // Presents one word, holds it until taken, then books its expected result.
  // With drain set, the sender first waits until every result is back.
  task automatic send_word(input item_t w, input bit typed, input verdict_t tv,
                           input bit drain);
    int unsigned gap;
    verdict_t    v;
    gap = pick_gap();
    if (gap > 0 || (drain && verdict_q.size() != 0)) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      if (drain) begin
        while (verdict_q.size() != 0) @(posedge clk_i);
      end
    end
    s_valid <= 1'b1;
    s_tdata <= {w.value, w.key};
    s_tuser <= {w.sel, w.cmd};
    do @(posedge clk_i); while (!s_ready);
    v = card_table_apply(w);
    cmd_tally[w.cmd]++;
    verdict_q.push_back(typed ? tv : v);
  endtask

  function automatic void add_row(input logic [CMD_W-1:0] cmd, input logic sel,
                                  input logic [KEY_W-1:0] key,
                                  input logic [DAT_W-1:0] value, input bit typed,
                                  input logic [CODE_W-1:0] code,
                                  input logic [DAT_W-1:0] data);
    row_t r;
    r.w     = '{cmd, sel, key, value};
    r.typed = typed;
    r.v     = '{code, data};
    dir_rows.push_back(r);
  endfunction

  function automatic item_t pick_random_word();
    item_t       w;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 3)       w.cmd = CMD_CLEAR;
    else if (r < 7)  w.cmd = 3'($urandom_range(CMD_SPARE5, CMD_SPARE7));
    else if (r < 37) w.cmd = CMD_CHECK;
    else if (r < 57) w.cmd = CMD_BLOCK;
    else if (r < 80) w.cmd = CMD_RECORD;
    else             w.cmd = CMD_UNBLOCK;
    w.sel   = 1'($urandom_range(0, 1));
    w.value = 8'($urandom);
    r = $urandom_range(0, 99);
    if (r < 70)      w.key = key_pool[$urandom_range(0, 15)];
    else if (r < 80) w.key = KEY_RESERVED;
    else             w.key = 24'($urandom);
    return w;
  endfunction

  // Stimulus: directed rows, fill of the manager table, random words.
  initial begin : stim
    item_t       w;
    int unsigned n;
    logic [KEY_W-1:0] k;
    fill_cnt[0] = 0;
    fill_cnt[1] = 0;
    foreach (key_pool[i]) key_pool[i] = 24'($urandom) & 24'hFFFFFE;

    //      cmd          sel  key          value  typed code         data
    add_row(CMD_CHECK,   0,   24'h000000,  8'h00, 1,    RES_ABSENT,  NO_DATA);
    add_row(CMD_CHECK,   1,   KEY_RESERVED, 8'h00, 1,   RES_ABSENT,  NO_DATA);
    add_row(CMD_BLOCK,   0,   24'h000000,  8'h3C, 1,    RES_OK,      NO_DATA);
    add_row(CMD_CHECK,   0,   24'h000000,  8'h00, 1,    RES_BLOCKED, NO_DATA);
    add_row(CMD_BLOCK,   0,   24'h000000,  8'h00, 1,    RES_UPDATED, NO_DATA);
    add_row(CMD_RECORD,  0,   24'h000000,  8'hA5, 1,    RES_OK,      NO_DATA);
    add_row(CMD_CHECK,   0,   24'h000000,  8'h00, 1,    RES_LISTED,  8'hA5);
    add_row(CMD_UNBLOCK, 0,   24'h000000,  8'h00, 1,    RES_OK,      NO_DATA);
    add_row(CMD_RECORD,  1,   24'hFFFFFE,  8'h00, 1,    RES_OK,      NO_DATA);
    add_row(CMD_RECORD,  1,   24'h800001,  8'hFF, 1,    RES_OK,      NO_DATA);
    add_row(CMD_CHECK,   1,   24'hFFFFFE,  8'h00, 1,    RES_LISTED,  8'h00);
    add_row(CMD_CHECK,   1,   24'h000000,  8'h00, 1,    RES_ABSENT,  NO_DATA);
    add_row(CMD_BLOCK,   1,   24'hFFFFFE,  8'h00, 0,    RES_FAIL,    NO_DATA);
    add_row(CMD_CHECK,   1,   24'hFFFFFE,  8'h00, 0,    RES_FAIL,    NO_DATA);
    add_row(CMD_UNBLOCK, 1,   24'hFFFFFE,  8'h00, 0,    RES_FAIL,    NO_DATA);
    add_row(CMD_CHECK,   1,   24'h800001,  8'h00, 0,    RES_FAIL,    NO_DATA);
    add_row(CMD_BLOCK,   0,   KEY_RESERVED, 8'h00, 1,   RES_OK,      NO_DATA);
    add_row(CMD_RECORD,  1,   KEY_RESERVED, 8'h55, 1,   RES_OK,      NO_DATA);
    add_row(CMD_UNBLOCK, 0,   KEY_RESERVED, 8'h00, 1,   RES_OK,      NO_DATA);
    add_row(CMD_CHECK,   0,   KEY_RESERVED, 8'h00, 1,   RES_ABSENT,  NO_DATA);
    add_row(CMD_UNBLOCK, 0,   24'h123456,  8'h00, 1,    RES_OK,      NO_DATA);
    add_row(CMD_SPARE5,  0,   24'h000000,  8'h00, 1,    RES_FAIL,    NO_DATA);
    add_row(CMD_SPARE6,  1,   24'hFFFFFE,  8'hFF, 1,    RES_FAIL,    NO_DATA);
    add_row(CMD_SPARE7,  1,   KEY_RESERVED, 8'hFF, 1,   RES_FAIL,    NO_DATA);
    add_row(CMD_CLEAR,   0,   24'h000000,  8'h00, 1,    RES_OK,      NO_DATA);
    add_row(CMD_CHECK,   1,   24'hFFFFFE,  8'h00, 1,    RES_ABSENT,  NO_DATA);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].v, 1'b0);

    // Fill the manager table to capacity; keys are unique by their low bits.
    // A few words land in the normal table, and stored keys are read back.
    n = 0;
    while (fill_cnt[1] < ENTRIES) begin
      w.sel   = 1'b1;
      w.value = 8'($urandom);
      w.cmd   = $urandom_range(0, 1) ? CMD_BLOCK : CMD_RECORD;
      w.key   = {13'($urandom), 11'(n)};
      if (n % 32 == 31) begin
        w.cmd = CMD_CHECK;
        w.key = card_store[ENTRIES + $urandom_range(0, fill_cnt[1] - 1)].key;
      end else if (n % 64 == 13) begin
        w.sel = 1'b0;
      end
      send_word(w, 1'b0, '0, n == 0);
      n++;
    end

    // Probes of the full table, then one last look at the normal table and a clear.
    // The probe key's low bits lie beyond any fill index, so it is absent.
    k = card_store[ENTRIES + ENTRIES - 1].key;
    send_word('{CMD_BLOCK,   1'b1, 24'h0007FF, 8'h11}, 1'b1, '{RES_FAIL, NO_DATA}, 1'b1);
    send_word('{CMD_RECORD,  1'b1, 24'h0007FF, 8'h22}, 1'b1, '{RES_FAIL, NO_DATA}, 1'b0);
    send_word('{CMD_UNBLOCK, 1'b1, 24'h0007FF, 8'h00}, 1'b1, '{RES_FAIL, NO_DATA}, 1'b0);
    send_word('{CMD_CHECK,   1'b1, 24'h0007FF, 8'h00}, 1'b1, '{RES_ABSENT, NO_DATA}, 1'b0);
    send_word('{CMD_BLOCK,   1'b1, KEY_RESERVED, 8'h00}, 1'b1, '{RES_FAIL, NO_DATA}, 1'b0);
    send_word('{CMD_RECORD,  1'b1, KEY_RESERVED, 8'h00}, 1'b1, '{RES_FAIL, NO_DATA}, 1'b0);
    send_word('{CMD_UNBLOCK, 1'b1, KEY_RESERVED, 8'h00}, 1'b1, '{RES_FAIL, NO_DATA}, 1'b0);
    send_word('{CMD_CHECK,   1'b1, KEY_RESERVED, 8'h00}, 1'b1, '{RES_ABSENT, NO_DATA}, 1'b0);
    send_word('{CMD_BLOCK,   1'b1, k, 8'h00}, 1'b0, '0, 1'b0);
    send_word('{CMD_CHECK,   1'b1, k, 8'h00}, 1'b0, '0, 1'b0);
    send_word('{CMD_RECORD,  1'b1, k, 8'h77}, 1'b0, '0, 1'b0);
    send_word('{CMD_CHECK,   1'b1, k, 8'h00}, 1'b0, '0, 1'b0);
    send_word('{CMD_UNBLOCK, 1'b1, card_store[ENTRIES].key, 8'h00}, 1'b0, '0, 1'b0);
    send_word('{CMD_CHECK,   1'b1, card_store[ENTRIES].key, 8'h00}, 1'b0, '0, 1'b0);
    send_word('{CMD_CHECK,   1'b0, card_store[0].key, 8'h00}, 1'b0, '0, 1'b0);
    send_word('{CMD_CLEAR,   1'b1, 24'h000000, 8'h00}, 1'b1, '{RES_OK, NO_DATA}, 1'b0);

    // Random words; clears are rare so fill counts stay small.
    for (int unsigned i = 0; i < N_RANDOM; i++) begin
      if (i % 50 == 0) calm = ($urandom_range(0, 3) == 0);
      w = pick_random_word();
      send_word(w, 1'b0, '0, $urandom_range(0, 49) == 0);
    end
    s_valid <= 1'b0;

    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (ENTRIES + 8) @(posedge clk_i);
    if (verdict_q.size() != 0) begin
      $error("%0d result words never arrived", verdict_q.size());
      err_cnt++;
    end

    $display("Covered %0d check, %0d block, %0d record, %0d unblock, %0d clear, %0d spare",
             cmd_tally[0], cmd_tally[1], cmd_tally[2], cmd_tally[3], cmd_tally[4],
             cmd_tally[5] + cmd_tally[6] + cmd_tally[7]);
    $display("Key hits %0d, full-table rejects %0d, peak fill %0d of %0d",
             hit_cnt, reject_cnt, peak_fill, ENTRIES);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Result side: random stalls on tready, in-order compare of every word.
  initial begin : sink
    int unsigned stall;
    verdict_t    v;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_valid && m_ready) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected result word: code %0d data 0x%02h", m_tuser, m_tdata);
          err_cnt++;
        end else begin
          v = verdict_q.pop_front();
          if (m_tuser !== v.code) begin
            $error("code mismatch: expected %0d, got %0d", v.code, m_tuser);
            err_cnt++;
          end
          if (m_tdata !== v.data) begin
            $error("data mismatch: expected 0x%02h, got 0x%02h", v.data, m_tdata);
            err_cnt++;
          end
        end
      end
      if (stall > 0) begin
        m_ready <= 1'b0;
        stall--;
      end else begin
        m_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = pick_gap();
      end
    end
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
hdl/cblt_pkg.sv
hdl/cblt_ram.sv
hdl/cblt_ctrl.sv
hdl/card_block_list_table.sv
bench/tb_top.sv
